// ===== hw/rtl/pulsar_antenna_pattern_core_defines.svh =====
// Assertion macros shared by the antenna pattern RTL.
`ifndef PULSAR_ANTENNA_PATTERN_CORE_DEFINES_SVH
`define PULSAR_ANTENNA_PATTERN_CORE_DEFINES_SVH
`ifndef SYNTH
`define PAP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PAP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PAP_ASSERT_NOW(lbl, ante, cons)
`define PAP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/pap_pkg.sv =====
// Types, constants and the CORDIC angle table for the antenna pattern core.
`timescale 1ns / 1ps
package pap_pkg;
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 20;
  localparam int DIV_BITS          = 33;
  localparam int NUM_W             = 37;
  localparam int DIVN_W            = 66;

  typedef logic signed [33:0] cw_t;
  typedef logic signed [32:0] q_t;
  typedef logic signed [NUM_W-1:0] num_t;

  localparam q_t  ONE_Q30 = 33'sd1073741824;
  localparam cw_t GAIN_Q30 = 34'sd652032874;

  function automatic cw_t atan_turn(input int i);
    cw_t r;
    case (i)
      0: r = 34'sd536870912;  1: r = 34'sd316933406;  2: r = 34'sd167458907;
      3: r = 34'sd85004756;   4: r = 34'sd42667331;   5: r = 34'sd21354465;
      6: r = 34'sd10680350;   7: r = 34'sd5340245;    8: r = 34'sd2670163;
      9: r = 34'sd1335087;    10: r = 34'sd667544;    11: r = 34'sd333772;
      12: r = 34'sd166886;    13: r = 34'sd83443;     14: r = 34'sd41722;
      15: r = 34'sd20861;     16: r = 34'sd10430;     17: r = 34'sd5215;
      18: r = 34'sd2608;      19: r = 34'sd1304;      20: r = 34'sd652;
      21: r = 34'sd326;       22: r = 34'sd163;       23: r = 34'sd81;
      24: r = 34'sd41;        25: r = 34'sd20;        26: r = 34'sd10;
      27: r = 34'sd5;         28: r = 34'sd3;         29: r = 34'sd1;
      30: r = 34'sd1;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  function automatic q_t mulq(input q_t a, input q_t b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b) + 66'sd536870912;
    return 33'(p >>> 30);
  endfunction

  function automatic q_t clampq(input cw_t v);
    q_t r;
    if (v > 34'sd1073741824) r = ONE_Q30;
    else if (v < -34'sd1073741824) r = -ONE_Q30;
    else r = 33'(v);
    return r;
  endfunction
endpackage

// ===== hw/rtl/pulsar_antenna_pattern_core.sv =====
// Antenna pattern core: CORDIC trig, tensor contraction and pipelined divide.
// channel | dir | fields
// in_     | in  | tdata: source_ra, source_dec, pulsar_ra, pulsar_dec
// out_    | out | tdata: cos_separation, plus_response, cross_response; tuser: aligned
// One transfer per cycle in and out while the output is not stalled.
// Most of the latency comes from the CORDIC iteration chain and the 33 radix-2 divide steps.
// rst_n is synchronous and clears the valid bits only.
// A stalled output freezes the whole pipeline; in_tready follows that enable.
`timescale 1ns / 1ps
`include "pulsar_antenna_pattern_core_defines.svh"
module pulsar_antenna_pattern_core #(
  parameter int ANGLE_BITS    = pap_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = pap_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // source_ra, source_dec, pulsar_ra, pulsar_dec
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // cos_separation, plus_response, cross_response
  output logic [0:0]  out_tuser   // aligned
);
  import pap_pkg::*;

  localparam int NL = 6;  // lanes: lam, bet, lamp, betp, lam-lamp, 2*lam

  function automatic logic [31:0] to_turn(input logic [15:0] f);
    logic [63:0] e;
    e = {48'd0, f} & ((64'd1 << ANGLE_BITS) - 64'd1);
    return 32'(e << (32 - ANGLE_BITS));
  endfunction

  logic en;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  logic [31:0] ang [NL];
  always_comb begin
    ang[0] = to_turn(in_tdata[15:0]);
    ang[1] = to_turn(in_tdata[31:16]);
    ang[2] = to_turn(in_tdata[47:32]);
    ang[3] = to_turn(in_tdata[63:48]);
    ang[4] = ang[0] - ang[2];
    ang[5] = ang[0] << 1;
  end

  // CORDIC pipeline
  logic       cv_r [0:CORDIC_STAGES];
  cw_t        cx_r [0:CORDIC_STAGES][NL];
  cw_t        cy_r [0:CORDIC_STAGES][NL];
  cw_t        cz_r [0:CORDIC_STAGES][NL];
  logic [1:0] cq_r [0:CORDIC_STAGES][NL];

  always_ff @(posedge clk) begin
    logic [31:0] t;
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else if (en) begin
      cv_r[0] <= in_tvalid;
    end
    if (en) begin
      for (int j = 0; j < NL; j++) begin
        t = ang[j] + 32'h2000_0000;
        cq_r[0][j] <= t[31:30];
        cz_r[0][j] <= $signed({4'd0, t[29:0]}) - 34'sh2000_0000;
        cx_r[0][j] <= GAIN_Q30;
        cy_r[0][j] <= '0;
      end
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[k+1] <= 1'b0;
      end else if (en) begin
        cv_r[k+1] <= cv_r[k];
      end
      if (en) begin
        for (int j = 0; j < NL; j++) begin
          cq_r[k+1][j] <= cq_r[k][j];
          if (cz_r[k][j] >= 0) begin
            cx_r[k+1][j] <= cx_r[k][j] - (cy_r[k][j] >>> k);
            cy_r[k+1][j] <= cy_r[k][j] + (cx_r[k][j] >>> k);
            cz_r[k+1][j] <= cz_r[k][j] - atan_turn(k);
          end else begin
            cx_r[k+1][j] <= cx_r[k][j] + (cy_r[k][j] >>> k);
            cy_r[k+1][j] <= cy_r[k][j] - (cx_r[k][j] >>> k);
            cz_r[k+1][j] <= cz_r[k][j] + atan_turn(k);
          end
        end
      end
    end
  end

  // quadrant map
  logic vb_r;
  q_t   c_r [NL];
  q_t   s_r [NL];
  always_ff @(posedge clk) begin
    q_t xc, yc;
    if (!rst_n) vb_r <= 1'b0;
    else if (en) vb_r <= cv_r[CORDIC_STAGES];
    if (en) begin
      for (int j = 0; j < NL; j++) begin
        xc = clampq(cx_r[CORDIC_STAGES][j]);
        yc = clampq(cy_r[CORDIC_STAGES][j]);
        case (cq_r[CORDIC_STAGES][j])
          2'd0: begin c_r[j] <= xc;  s_r[j] <= yc;  end
          2'd1: begin c_r[j] <= -yc; s_r[j] <= xc;  end
          2'd2: begin c_r[j] <= -xc; s_r[j] <= -yc; end
          default: begin c_r[j] <= yc; s_r[j] <= -xc; end
        endcase
      end
    end
  end

  // product level 1
  logic v1_r;
  q_t n1_r, n2_r, n3_r, cbcbp_r, sbsbp_r, cd1_r, sb2_r, sbcb_r, clcl_r, slsl_r, slcl_r;
  q_t cl1_r, sl1_r, ep33_r, ex11_r, ex12_r, ex13_r, ex23_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= vb_r;
    if (en) begin
      n1_r    <= mulq(c_r[2], c_r[3]);
      n2_r    <= mulq(s_r[2], c_r[3]);
      n3_r    <= s_r[3];
      cbcbp_r <= mulq(c_r[1], c_r[3]);
      sbsbp_r <= mulq(s_r[1], s_r[3]);
      cd1_r   <= c_r[4];
      sb2_r   <= mulq(s_r[1], s_r[1]);
      sbcb_r  <= mulq(s_r[1], c_r[1]);
      clcl_r  <= mulq(c_r[0], c_r[0]);
      slsl_r  <= mulq(s_r[0], s_r[0]);
      slcl_r  <= mulq(s_r[0], c_r[0]);
      cl1_r   <= c_r[0];
      sl1_r   <= s_r[0];
      ep33_r  <= -mulq(c_r[1], c_r[1]);
      ex11_r  <= mulq(s_r[5], s_r[1]);
      ex12_r  <= -mulq(c_r[5], s_r[1]);
      ex13_r  <= -mulq(s_r[0], c_r[1]);
      ex23_r  <= mulq(c_r[0], c_r[1]);
    end
  end

  // product level 2
  logic v2_r;
  q_t cosmu_r, ep11_r, ep22_r, ep33b_r, ep12_r, ep13_r, ep23_r;
  q_t x11_r, x12_r, x13_r, x23_r;
  q_t m11_r, m22_r, m33_r, m12_r, m13_r, m23_r;
  always_ff @(posedge clk) begin
    logic signed [33:0] cs;
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
    if (en) begin
      cs = 34'(mulq(cbcbp_r, cd1_r)) + 34'(sbsbp_r);
      cosmu_r <= clampq(cs);
      ep11_r  <= slsl_r - mulq(clcl_r, sb2_r);
      ep22_r  <= clcl_r - mulq(slsl_r, sb2_r);
      ep33b_r <= ep33_r;
      ep12_r  <= -mulq(slcl_r, sb2_r + ONE_Q30);
      ep13_r  <= mulq(cl1_r, sbcb_r);
      ep23_r  <= mulq(sl1_r, sbcb_r);
      x11_r   <= ex11_r;
      x12_r   <= ex12_r;
      x13_r   <= ex13_r;
      x23_r   <= ex23_r;
      m11_r   <= mulq(n1_r, n1_r);
      m22_r   <= mulq(n2_r, n2_r);
      m33_r   <= mulq(n3_r, n3_r);
      m12_r   <= mulq(n1_r, n2_r);
      m13_r   <= mulq(n1_r, n3_r);
      m23_r   <= mulq(n2_r, n3_r);
    end
  end

  // product level 3
  logic v3_r;
  q_t cosmu3_r;
  q_t tp11_r, tp22_r, tp33_r, tp12_r, tp13_r, tp23_r;
  q_t tx11_r, tx22_r, tx12_r, tx13_r, tx23_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
    if (en) begin
      cosmu3_r <= cosmu_r;
      tp11_r <= mulq(m11_r, ep11_r);
      tp22_r <= mulq(m22_r, ep22_r);
      tp33_r <= mulq(m33_r, ep33b_r);
      tp12_r <= mulq(m12_r, ep12_r);
      tp13_r <= mulq(m13_r, ep13_r);
      tp23_r <= mulq(m23_r, ep23_r);
      tx11_r <= mulq(m11_r, x11_r);
      tx22_r <= mulq(m22_r, -x11_r);
      tx12_r <= mulq(m12_r, x12_r);
      tx13_r <= mulq(m13_r, x13_r);
      tx23_r <= mulq(m23_r, x23_r);
    end
  end

  // sums and denominator
  logic        v4_r, al4_r;
  q_t          cosmu4_r;
  num_t        nump_r, numx_r;
  logic [31:0] den4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
    if (en) begin
      cosmu4_r <= cosmu3_r;
      al4_r    <= (cosmu3_r == ONE_Q30);
      den4_r   <= 32'(ONE_Q30 - cosmu3_r);
      nump_r   <= NUM_W'(tp11_r) + NUM_W'(tp22_r) + NUM_W'(tp33_r)
                + ((NUM_W'(tp12_r) + NUM_W'(tp13_r) + NUM_W'(tp23_r)) <<< 1);
      numx_r   <= NUM_W'(tx11_r) + NUM_W'(tx22_r)
                + ((NUM_W'(tx12_r) + NUM_W'(tx13_r) + NUM_W'(tx23_r)) <<< 1);
    end
  end

  // radix-2 divider, both patterns share the denominator
  logic                dv_r   [0:DIV_BITS];
  logic                dal_r  [0:DIV_BITS];
  q_t                  dcos_r [0:DIV_BITS];
  logic [31:0]         dd_r   [0:DIV_BITS];
  logic [1:0]          dneg_r [0:DIV_BITS];
  logic [1:0]          dovf_r [0:DIV_BITS];
  logic [32:0]         drem_r [0:DIV_BITS][2];
  logic [DIV_BITS-1:0] dlo_r  [0:DIV_BITS][2];
  logic [DIV_BITS-1:0] dq_r   [0:DIV_BITS][2];

  always_ff @(posedge clk) begin
    logic [NUM_W-1:0]  mag;
    logic [DIVN_W-1:0] nn;
    num_t              nv;
    if (!rst_n) dv_r[0] <= 1'b0;
    else if (en) dv_r[0] <= v4_r;
    if (en) begin
      dal_r[0]  <= al4_r;
      dcos_r[0] <= cosmu4_r;
      dd_r[0]   <= den4_r;
      for (int l = 0; l < 2; l++) begin
        nv  = (l == 0) ? nump_r : numx_r;
        mag = nv[NUM_W-1] ? NUM_W'(-nv) : NUM_W'(nv);
        nn  = (DIVN_W'(mag) << 28) + DIVN_W'(den4_r >> 1);
        dneg_r[0][l]  <= nv[NUM_W-1];
        dovf_r[0][l]  <= (nn[DIVN_W-1:DIV_BITS] >= {1'b0, den4_r});
        drem_r[0][l]  <= nn[DIV_BITS+32:DIV_BITS];
        dlo_r[0][l]   <= nn[DIV_BITS-1:0];
        dq_r[0][l]    <= '0;
      end
    end
  end

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    always_ff @(posedge clk) begin
      logic [32:0] sh;
      if (!rst_n) dv_r[k+1] <= 1'b0;
      else if (en) dv_r[k+1] <= dv_r[k];
      if (en) begin
        dal_r[k+1]  <= dal_r[k];
        dcos_r[k+1] <= dcos_r[k];
        dd_r[k+1]   <= dd_r[k];
        dneg_r[k+1] <= dneg_r[k];
        dovf_r[k+1] <= dovf_r[k];
        for (int l = 0; l < 2; l++) begin
          dlo_r[k+1][l] <= dlo_r[k][l];
          sh = {drem_r[k][l][31:0], dlo_r[k][l][DIV_BITS-1-k]};
          if (sh >= {1'b0, dd_r[k]}) begin
            drem_r[k+1][l] <= sh - {1'b0, dd_r[k]};
            dq_r[k+1][l]   <= {dq_r[k][l][DIV_BITS-2:0], 1'b1};
          end else begin
            drem_r[k+1][l] <= sh;
            dq_r[k+1][l]   <= {dq_r[k][l][DIV_BITS-2:0], 1'b0};
          end
        end
      end
    end
  end

  // saturation and output register
  logic        out_valid_r;
  logic [31:0] res_r [2];
  logic [31:0] cos_r;
  logic        al_r;
  always_ff @(posedge clk) begin
    logic [DIV_BITS-1:0] qv;
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= dv_r[DIV_BITS];
    if (en) begin
      cos_r <= 32'(dcos_r[DIV_BITS]);
      al_r  <= dal_r[DIV_BITS];
      for (int l = 0; l < 2; l++) begin
        qv = dq_r[DIV_BITS][l];
        if (dal_r[DIV_BITS]) res_r[l] <= '0;
        else if (dneg_r[DIV_BITS][l]) begin
          if (dovf_r[DIV_BITS][l] || qv > 33'h0_8000_0000) res_r[l] <= 32'h8000_0000;
          else res_r[l] <= 32'(-qv);
        end else begin
          if (dovf_r[DIV_BITS][l] || qv > 33'h0_7FFF_FFFF) res_r[l] <= 32'h7FFF_FFFF;
          else res_r[l] <= qv[31:0];
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r[1], res_r[0], cos_r};
  assign out_tuser  = al_r;

  `PAP_ASSERT_NOW(a_aligned_zero, out_tvalid && out_tuser[0], out_tdata[95:32] == 64'd0)
  `PAP_ASSERT_NOW(a_aligned_cos, out_tvalid, out_tuser[0] == (out_tdata[31:0] == 32'h4000_0000))
  `PAP_ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready, $stable(dv_r[DIV_BITS]))
endmodule
